// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the dominant color debouncer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define DCD_ASSERT_IMP(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
		else $error("dcd assertion failed");
// next-cycle implication, checked out of reset
`define DCD_ASSERT_NEXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
		else $error("dcd assertion failed");
`else
`define DCD_ASSERT_IMP(lbl, ck, rn, a, b)
`define DCD_ASSERT_NEXT(lbl, ck, rn, a, b)
`endif

`endif

// ===== rtl/dcd_pkg.sv =====
// shared constants, types and codes of the dominant color debouncer
package dcd_pkg;

	// fixed point layout of a normalized channel
	localparam int RAW_BITS      = 16;
	localparam int FRACTION_BITS = 8;
	localparam int NORM_INT_BITS = 9;
	localparam int SCALE_SHIFT   = 8;
	localparam int NORM_W        = NORM_INT_BITS + FRACTION_BITS;
	localparam int DIV_W         = RAW_BITS + SCALE_SHIFT + FRACTION_BITS;

	// deviation sum and dominance products
	localparam int SUM_W    = NORM_W + 2;
	localparam int INTSUM_W = SUM_W - FRACTION_BITS;
	localparam int PCT_W    = 7;
	localparam int HOLD_W   = 16;
	localparam int PROD_W   = PCT_W + SUM_W;
	localparam int PCT_SCALE = 100;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DOMINANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 1'b1;
	localparam logic [PCT_W-1:0]  PERCENT_RESET = 7'd55;
	localparam logic [HOLD_W-1:0] HOLD_RESET    = 16'd2000;

	typedef logic [NORM_W-1:0] norm_t;
	localparam norm_t NORM_MAX  = '1;
	localparam norm_t OFFSET_RG = norm_t'(20 << FRACTION_BITS);
	localparam norm_t OFFSET_B  = norm_t'(60 << FRACTION_BITS);
	localparam logic [HOLD_W-1:0] ELAPSED_MAX = '1;

	// request codes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// reference modes
	localparam logic [1:0] MODE_KEEP  = 2'd0;
	localparam logic [1:0] MODE_RED   = 2'd1;
	localparam logic [1:0] MODE_GREEN = 2'd2;
	localparam logic [1:0] MODE_BLUE  = 2'd3;

	typedef enum logic [1:0] {
		COLOR_RED   = 2'd0,
		COLOR_GREEN = 2'd1,
		COLOR_BLUE  = 2'd2
	} color_t;

	// divider request and response
	typedef struct packed {
		logic                start;
		logic [RAW_BITS-1:0] raw;
		logic [RAW_BITS-1:0] clear;
	} div_req_t;

	typedef struct packed {
		logic  done;
		norm_t quotient;
	} div_rsp_t;

endpackage

// ===== rtl/dcd_divider.sv =====
// shared restoring divider: one quotient bit of raw*256/clear per cycle, saturating
`include "assert_macros.svh"

module dcd_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  dcd_pkg::div_req_t req,
	output dcd_pkg::div_rsp_t rsp
);
	import dcd_pkg::*;

	localparam int CNT_W = $clog2(NORM_W + 1);
	localparam int CMP_W = RAW_BITS + NORM_INT_BITS;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    count_q;
	logic [RAW_BITS-1:0] rem_q;
	logic [RAW_BITS-1:0] clear_q;
	norm_t               low_q;
	norm_t               quot_q;

	logic [DIV_W-1:0]    dividend;
	logic [CMP_W-1:0]    scaled_raw;
	logic [CMP_W-1:0]    scaled_clear;
	logic                saturate;
	logic [RAW_BITS:0]   trial;
	logic                fits;

	// saturation is known up front: quotient too big or divide by zero
	assign dividend     = DIV_W'(req.raw) << (SCALE_SHIFT + FRACTION_BITS);
	assign scaled_raw   = CMP_W'(req.raw) << SCALE_SHIFT;
	assign scaled_clear = CMP_W'(req.clear) << NORM_INT_BITS;
	assign saturate     = (req.clear == '0) || (scaled_raw >= scaled_clear);

	// one trial subtraction per step
	assign trial = {rem_q, low_q[NORM_W-1]};
	assign fits  = trial >= {1'b0, clear_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= req.start ? saturate : (busy_q && count_q == CNT_W'(1));
			if (req.start) begin
				if (!saturate) begin
					busy_q  <= 1'b1;
					count_q <= CNT_W'(NORM_W);
				end
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder and quotient datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q  <= saturate ? NORM_MAX : '0;
			rem_q   <= RAW_BITS'(dividend[DIV_W-1:NORM_W]);
			low_q   <= dividend[NORM_W-1:0];
			clear_q <= req.clear;
		end else if (busy_q) begin
			quot_q <= {quot_q[NORM_W-2:0], fits};
			rem_q  <= fits ? RAW_BITS'(trial - {1'b0, clear_q}) : trial[RAW_BITS-1:0];
			low_q  <= low_q << 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

	`DCD_ASSERT_IMP(a_no_restart_busy, clk, arst_n, req.start, !busy_q)
	`DCD_ASSERT_NEXT(a_done_single, clk, arst_n, done_q, !done_q)

endmodule

// ===== rtl/dominant_color_debouncer.sv =====
// Dominant color debouncer. A tick request (opcode 0) gives no result. A sample request
// (opcode 1) normalizes red, green and blue by the clear count in one shared divider that
// retires one quotient bit per cycle, channel by channel, then evaluates and decides; a
// saturated channel is finished without division steps. sample_stall is high while a
// sample is in progress. The result waits in an output register and the next request is
// taken while it is still stalled; a new decision only waits if the previous result has
// not left yet. Configuration writes take effect on the next cycle.
`include "assert_macros.svh"

module dominant_color_debouncer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcd_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic                         opcode,
	input  logic [dcd_pkg::RAW_BITS-1:0] raw_red,
	input  logic [dcd_pkg::RAW_BITS-1:0] raw_green,
	input  logic [dcd_pkg::RAW_BITS-1:0] raw_blue,
	input  logic [dcd_pkg::RAW_BITS-1:0] raw_clear,
	input  logic [1:0]                   reference_mode,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [1:0]                   held_color,
	output logic [1:0]                   candidate_color,
	output logic                         dominant,
	output logic                         color_changed
);
	import dcd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_EVAL,
		ST_DECIDE
	} state_t;

	state_t              state_q;
	color_t              chan_q;
	logic [PCT_W-1:0]    percent_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [1:0]          offset_mode_q;
	color_t              held_q;
	logic                armed_q;
	logic [HOLD_W-1:0]   elapsed_q;
	logic                result_valid_q;
	color_t              held_out_q;
	color_t              cand_out_q;
	logic                dominant_q;
	logic                changed_q;

	logic [RAW_BITS-1:0] red_q, green_q, blue_q, clear_q;
	norm_t               dev_r_q, dev_g_q, dev_b_q;
	color_t              cand_q;
	logic [PROD_W-1:0]   prod_a_q;
	logic [PCT_W+INTSUM_W-1:0] prod_b_q;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                sample_take;
	logic                out_free;
	norm_t               chan_off;
	norm_t               dev_new;
	color_t              cand_sel;
	norm_t               maxdev;
	logic [SUM_W-1:0]    dev_sum;
	logic [INTSUM_W-1:0] intsum;
	logic                dom;
	logic                adopt;

	assign sample_stall = (state_q != ST_IDLE);
	assign sample_take  = sample_valid && !sample_stall;
	assign out_free     = !result_valid_q || !result_stall;

	// divider request: channel selected by the sequencer
	always_comb begin
		div_req.start = (state_q == ST_START);
		div_req.clear = clear_q;
		unique case (chan_q)
			COLOR_RED:   div_req.raw = red_q;
			COLOR_GREEN: div_req.raw = green_q;
			COLOR_BLUE:  div_req.raw = blue_q;
			default:     div_req.raw = blue_q;
		endcase
	end

	dcd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// reference offset of the channel in flight, then absolute deviation
	always_comb begin
		chan_off = '0;
		if (offset_mode_q == MODE_RED && chan_q == COLOR_RED)
			chan_off = OFFSET_RG;
		else if (offset_mode_q == MODE_GREEN && chan_q == COLOR_GREEN)
			chan_off = OFFSET_RG;
		else if (offset_mode_q == MODE_BLUE && chan_q == COLOR_BLUE)
			chan_off = OFFSET_B;
		dev_new = (div_rsp.quotient >= chan_off) ? div_rsp.quotient - chan_off
			: chan_off - div_rsp.quotient;
	end

	// argmax with ties toward the later channel, and the truncated sum
	always_comb begin
		if (dev_r_q > dev_g_q)
			cand_sel = (dev_r_q > dev_b_q) ? COLOR_RED : COLOR_BLUE;
		else
			cand_sel = (dev_g_q > dev_b_q) ? COLOR_GREEN : COLOR_BLUE;
		unique case (cand_sel)
			COLOR_RED:   maxdev = dev_r_q;
			COLOR_GREEN: maxdev = dev_g_q;
			COLOR_BLUE:  maxdev = dev_b_q;
			default:     maxdev = dev_b_q;
		endcase
		dev_sum = SUM_W'(dev_r_q) + SUM_W'(dev_g_q) + SUM_W'(dev_b_q);
		intsum  = dev_sum[SUM_W-1:FRACTION_BITS];
	end

	// dominance test and adoption after the hold time
	assign dom   = prod_a_q > {prod_b_q, {FRACTION_BITS{1'b0}}};
	assign adopt = dom && (cand_q != held_q) && armed_q && (elapsed_q > hold_q);

	// sequencer, debounce state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			chan_q         <= COLOR_RED;
			percent_q      <= PERCENT_RESET;
			hold_q         <= HOLD_RESET;
			offset_mode_q  <= MODE_KEEP;
			held_q         <= COLOR_RED;
			armed_q        <= 1'b0;
			elapsed_q      <= '0;
			result_valid_q <= 1'b0;
			held_out_q     <= COLOR_RED;
			cand_out_q     <= COLOR_RED;
			dominant_q     <= 1'b0;
			changed_q      <= 1'b0;
		end else begin
			// result leaves unless a new decision replaces it
			if (result_valid_q && !result_stall && state_q != ST_DECIDE)
				result_valid_q <= 1'b0;

			if (cfg_write) begin
				unique case (cfg_index)
					REG_DOMINANCE: percent_q <= cfg_data[PCT_W-1:0];
					REG_HOLD:      hold_q    <= cfg_data[HOLD_W-1:0];
					default:       percent_q <= percent_q;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (sample_take) begin
						if (opcode == OP_TICK) begin
							if (armed_q && elapsed_q != ELAPSED_MAX)
								elapsed_q <= elapsed_q + 1'b1;
						end else begin
							if (reference_mode != MODE_KEEP)
								offset_mode_q <= reference_mode;
							chan_q  <= COLOR_RED;
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						unique case (chan_q)
							COLOR_RED: begin
								chan_q  <= COLOR_GREEN;
								state_q <= ST_START;
							end
							COLOR_GREEN: begin
								chan_q  <= COLOR_BLUE;
								state_q <= ST_START;
							end
							default: begin
								state_q <= ST_EVAL;
							end
						endcase
					end
				end
				ST_EVAL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (out_free) begin
						if (!dom) begin
							armed_q <= 1'b0;
						end else if (cand_q != held_q) begin
							if (!armed_q) begin
								armed_q   <= 1'b1;
								elapsed_q <= '0;
							end else if (elapsed_q > hold_q) begin
								held_q    <= cand_q;
								armed_q   <= 1'b0;
								elapsed_q <= '0;
							end
						end else begin
							armed_q   <= 1'b0;
							elapsed_q <= '0;
						end
						held_out_q     <= adopt ? cand_q : held_q;
						cand_out_q     <= cand_q;
						dominant_q     <= dom;
						changed_q      <= adopt;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sample capture, deviations and dominance products
	always_ff @(posedge clk) begin
		if (sample_take) begin
			red_q   <= raw_red;
			green_q <= raw_green;
			blue_q  <= raw_blue;
			clear_q <= raw_clear;
		end
		if (state_q == ST_WAIT && div_rsp.done) begin
			unique case (chan_q)
				COLOR_RED:   dev_r_q <= dev_new;
				COLOR_GREEN: dev_g_q <= dev_new;
				default:     dev_b_q <= dev_new;
			endcase
		end
		if (state_q == ST_EVAL) begin
			cand_q   <= cand_sel;
			prod_a_q <= PROD_W'(maxdev) * PROD_W'(PCT_SCALE);
			prod_b_q <= (PCT_W+INTSUM_W)'(percent_q) * (PCT_W+INTSUM_W)'(intsum);
		end
	end

	assign result_valid    = result_valid_q;
	assign held_color      = held_out_q;
	assign candidate_color = cand_out_q;
	assign dominant        = dominant_q;
	assign color_changed   = changed_q;

	`DCD_ASSERT_IMP(a_change_consistent, clk, arst_n, result_valid && color_changed, dominant && candidate_color == held_color)
	`DCD_ASSERT_NEXT(a_unarmed_no_count, clk, arst_n, !armed_q, elapsed_q == $past(elapsed_q) || elapsed_q == '0)
	`DCD_ASSERT_IMP(a_result_from_decide, clk, arst_n, $rose(result_valid_q), $past(state_q) == ST_DECIDE)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the dominant color debouncer
module tb;
	import dcd_pkg::*;

	localparam int FRAC = 8;
	localparam longint unsigned NORM_TOP = (64'd1 << (9 + FRAC)) - 1;
	localparam longint unsigned REF_RG = 64'd20 << FRAC;
	localparam longint unsigned REF_B = 64'd60 << FRAC;
	localparam int unsigned ELAPSED_TOP = 65535;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_PRINTS = 40;
	localparam logic [1:0] MODE_OF [3] = '{MODE_RED, MODE_GREEN, MODE_BLUE};

	typedef struct {
		bit          barrier;
		logic        op;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] clear;
		logic [1:0]  mode;
	} sensor_req_t;

	typedef struct {
		color_t held;
		color_t cand;
		logic   dominant;
		logic   changed;
	} verdict_t;

	// ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DOMINANCE;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	logic                 opcode = OP_TICK;
	logic [RAW_BITS-1:0]  raw_red = '0;
	logic [RAW_BITS-1:0]  raw_green = '0;
	logic [RAW_BITS-1:0]  raw_blue = '0;
	logic [RAW_BITS-1:0]  raw_clear = '0;
	logic [1:0]           reference_mode = MODE_KEEP;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [1:0]           held_color;
	logic [1:0]           candidate_color;
	logic                 dominant;
	logic                 color_changed;

	// stimulus and expected verdicts
	sensor_req_t pending [$];
	verdict_t    awaited_verdicts [$];
	sensor_req_t on_port;
	bit          idling = 1'b1;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          quiet_cycles = 0;

	// shadow of the debouncer state and registers
	int unsigned share_pct = PERCENT_RESET;
	int unsigned hold_limit = HOLD_RESET;
	logic [1:0]  ref_sel = MODE_KEEP;
	color_t      held_now = COLOR_RED;
	logic        timer_on = 1'b0;
	int unsigned ms_count = 0;

	// run statistics
	int mismatches = 0;
	int ticks_sent = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int dominant_seen = 0;
	int changes_seen = 0;
	int reg_writes = 0;

	dominant_color_debouncer dut (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("mismatch at %0t: %s", $time, what);
		end
	endtask

	// channel scaled by the clear count, saturating
	function automatic longint unsigned scaled(input logic [15:0] raw, input logic [15:0] clr);
		longint unsigned q;
		if (clr == 0) begin
			return NORM_TOP;
		end
		q = ({48'd0, raw} << (8 + FRAC)) / clr;
		return (q > NORM_TOP) ? NORM_TOP : q;
	endfunction

	function automatic longint unsigned spread(input longint unsigned a, input longint unsigned b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// advance the shadow state by one accepted request
	task automatic take_request(input sensor_req_t r);
		longint unsigned off_r, off_g, off_b, dr, dg, db, top, whole;
		color_t   pick;
		logic     dom, chg;
		verdict_t v;
		off_r = 0;
		off_g = 0;
		off_b = 0;
		if (r.op == OP_TICK) begin
			ticks_sent++;
			if (timer_on && ms_count < ELAPSED_TOP) begin
				ms_count++;
			end
		end else begin
			samples_sent++;
			if (r.mode != MODE_KEEP) begin
				ref_sel = r.mode;
			end
			case (ref_sel)
				MODE_RED: off_r = REF_RG;
				MODE_GREEN: off_g = REF_RG;
				MODE_BLUE: off_b = REF_B;
				default: ;
			endcase
			dr = spread(scaled(r.red, r.clear), off_r);
			dg = spread(scaled(r.green, r.clear), off_g);
			db = spread(scaled(r.blue, r.clear), off_b);

			// argmax, ties go to the later channel
			if (dr > dg) begin
				pick = (dr > db) ? COLOR_RED : COLOR_BLUE;
			end else begin
				pick = (dg > db) ? COLOR_GREEN : COLOR_BLUE;
			end
			top = (pick == COLOR_RED) ? dr : (pick == COLOR_GREEN) ? dg : db;
			whole = ((dr + dg + db) >> FRAC) << FRAC;
			dom = (top * 100) > (64'(share_pct) * whole);

			// debounce decision
			chg = 1'b0;
			if (!dom) begin
				timer_on = 1'b0;
			end else if (pick != held_now) begin
				if (!timer_on) begin
					timer_on = 1'b1;
					ms_count = 0;
				end else if (ms_count > hold_limit) begin
					held_now = pick;
					timer_on = 1'b0;
					ms_count = 0;
					chg = 1'b1;
				end
			end else begin
				timer_on = 1'b0;
				ms_count = 0;
			end
			v.held = held_now;
			v.cand = pick;
			v.dominant = dom;
			v.changed = chg;
			awaited_verdicts.push_back(v);
		end
	endtask

	task automatic check_result();
		verdict_t v;
		if (awaited_verdicts.size() == 0) begin
			flag_mismatch("result arrived with no verdict awaited");
		end else begin
			v = awaited_verdicts.pop_front();
			results_checked++;
			if (v.dominant) dominant_seen++;
			if (v.changed) changes_seen++;
			if (held_color !== v.held) begin
				flag_mismatch($sformatf("held_color %0d, predicted %0d", held_color, v.held));
			end
			if (candidate_color !== v.cand) begin
				flag_mismatch($sformatf("candidate_color %0d, predicted %0d",
					candidate_color, v.cand));
			end
			if (dominant !== v.dominant) begin
				flag_mismatch($sformatf("dominant %b, predicted %b", dominant, v.dominant));
			end
			if (color_changed !== v.changed) begin
				flag_mismatch($sformatf("color_changed %b, predicted %b",
					color_changed, v.changed));
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				take_request(on_port);
			end
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending.size() > 0 && pending[0].barrier) begin
					// hold off until every verdict is out
					sample_valid <= 1'b0;
					if (awaited_verdicts.size() == 0) begin
						pending.delete(0);
					end
				end else if (pending.size() > 0) begin
					on_port = pending.pop_front();
					opcode <= on_port.op;
					raw_red <= on_port.red;
					raw_green <= on_port.green;
					raw_blue <= on_port.blue;
					raw_clear <= on_port.clear;
					reference_mode <= on_port.mode;
					sample_valid <= 1'b1;
					if (idling && $urandom_range(0, 19) == 0) begin
						send_gap = $urandom_range(1, 18);
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				check_result();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (idling && $urandom_range(0, 11) == 0) begin
					recv_gap = $urandom_range(1, 18);
				end
			end
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a transfer", quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		reg_writes++;
		if (idx == REG_DOMINANCE) begin
			share_pct = val[6:0];
		end else begin
			hold_limit = val;
		end
	endtask

	// wait until nothing is queued, in flight or awaited
	task automatic drain();
		while (pending.size() != 0 || sample_valid || awaited_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_sample(input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic [15:0] c, input logic [1:0] mode);
		sensor_req_t q;
		q.barrier = 1'b0;
		q.op = OP_SAMPLE;
		q.red = r;
		q.green = g;
		q.blue = b;
		q.clear = c;
		q.mode = mode;
		pending.push_back(q);
	endtask

	// ticks carry random payload that must be ignored
	task automatic queue_ticks(input int n);
		sensor_req_t q;
		q.barrier = 1'b0;
		q.op = OP_TICK;
		repeat (n) begin
			q.red = 16'($urandom);
			q.green = 16'($urandom);
			q.blue = 16'($urandom);
			q.clear = 16'($urandom);
			q.mode = 2'($urandom);
			pending.push_back(q);
		end
	endtask

	task automatic queue_barrier();
		sensor_req_t q;
		q = '{barrier: 1'b1, op: OP_TICK, mode: MODE_KEEP, default: '0};
		pending.push_back(q);
	endtask

	// sample where one channel clearly stands out
	task automatic queue_tinted(input int col, input logic [1:0] mode);
		int unsigned cl, big;
		int unsigned ch [3];
		cl = $urandom_range(64, 65535);
		big = cl * $urandom_range(150, 500) / 256;
		if (big > 65535) big = 65535;
		for (int i = 0; i < 3; i++) begin
			ch[i] = cl * $urandom_range(0, 25) / 256;
		end
		ch[col] = big;
		queue_sample(ch[0][15:0], ch[1][15:0], ch[2][15:0], cl[15:0], mode);
	endtask

	// arbitrary sample, clear often zero or tiny
	task automatic queue_noise();
		logic [15:0] c;
		case ($urandom_range(0, 3))
			0: c = '0;
			1: c = 16'($urandom_range(1, 255));
			default: c = 16'($urandom);
		endcase
		queue_sample(16'($urandom) >> $urandom_range(0, 15),
			16'($urandom) >> $urandom_range(0, 15),
			16'($urandom) >> $urandom_range(0, 15), c, 2'($urandom));
	endtask

	// mostly debounce runs with random content, plus noise, tick bursts and broken runs
	task automatic fill_random(input int target, input bit with_pauses);
		int made, kind, reps, col, other, n, span;
		logic [1:0] mode;
		made = 0;
		span = (hold_limit + 4 > 50) ? 50 : hold_limit + 4;
		while (made < target) begin
			kind = $urandom_range(0, 9);
			col = $urandom_range(0, 2);
			if (kind < 6) begin
				mode = 2'($urandom);
				reps = $urandom_range(2, 5);
				repeat (reps) begin
					queue_tinted(col, mode);
					n = $urandom_range(0, span);
					queue_ticks(n);
					made += n + 1;
					if ($urandom_range(0, 1)) mode = MODE_KEEP;
				end
			end else if (kind < 8) begin
				queue_noise();
				made++;
			end else if (kind == 8) begin
				n = $urandom_range(1, 4);
				queue_ticks(n);
				made += n;
			end else begin
				// candidate flips before it can be adopted
				other = (col + $urandom_range(1, 2)) % 3;
				queue_tinted(col, MODE_KEEP);
				n = $urandom_range(0, span);
				queue_ticks(n);
				queue_tinted(other, MODE_KEEP);
				queue_ticks(1);
				queue_tinted(col, MODE_KEEP);
				made += n + 4;
			end
			if (with_pauses && $urandom_range(0, 39) == 0) begin
				queue_barrier();
			end
		end
	endtask

	// main sequence
	initial begin
		int col;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed requests under the reset settings
		queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, MODE_KEEP);
		queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001, MODE_KEEP);
		queue_sample(16'h0001, 16'h0000, 16'h0000, 16'hFFFF, MODE_KEEP);
		queue_sample(16'h8000, 16'h8000, 16'h0000, 16'hFFFF, MODE_KEEP);
		queue_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, MODE_RED);
		queue_sample(16'h0000, 16'h0000, 16'h0000, 16'd100, MODE_BLUE);
		queue_ticks(3);
		queue_sample(16'h0000, 16'h0000, 16'h0000, 16'd7, MODE_KEEP);
		queue_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001, MODE_GREEN);
		queue_sample(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, MODE_RED);
		queue_ticks(1);
		queue_sample(16'hAAAA, 16'h5555, 16'hFFFF, 16'h8000, MODE_GREEN);
		queue_ticks(1);
		queue_sample(16'h5555, 16'hAAAA, 16'h0000, 16'h7FFF, MODE_KEEP);
		drain();

		// lowest threshold, zero hold time
		write_reg(REG_DOMINANCE, 16'd0);
		write_reg(REG_HOLD, 16'd0);
		fill_random(300, 1'b1);
		drain();

		// full threshold with steady handshakes
		idling = 1'b0;
		write_reg(REG_DOMINANCE, 16'd100);
		write_reg(REG_HOLD, 16'd5);
		fill_random(150, 1'b0);
		drain();

		// threshold past one hundred percent
		idling = 1'b1;
		write_reg(REG_DOMINANCE, 16'd127);
		write_reg(REG_HOLD, 16'd3);
		fill_random(60, 1'b0);
		drain();

		// random settings with sender pauses
		repeat (3) begin
			write_reg(REG_DOMINANCE, 16'($urandom_range(0, 100)));
			write_reg(REG_HOLD, 16'($urandom_range(0, 40)));
			fill_random(120, 1'b1);
			queue_barrier();
			fill_random(120, 1'b1);
			drain();
		end

		// long hold: adoption only after the full tick count
		write_reg(REG_DOMINANCE, 16'd55);
		write_reg(REG_HOLD, 16'd200);
		col = (int'(held_now) + 1) % 3;
		queue_tinted(col, MODE_OF[col]);
		queue_ticks(200);
		queue_tinted(col, MODE_KEEP);
		queue_ticks(1);
		queue_tinted(col, MODE_KEEP);
		drain();

		// closing stretch, no idling on either side
		idling = 1'b0;
		write_reg(REG_DOMINANCE, 16'($urandom_range(40, 70)));
		write_reg(REG_HOLD, 16'($urandom_range(0, 20)));
		fill_random(200, 1'b0);
		drain();

		$display("run covered %0d ticks and %0d samples over %0d register writes",
			ticks_sent, samples_sent, reg_writes);
		$display("%0d results checked: %0d dominant, %0d color changes, %0d mismatches",
			results_checked, dominant_seen, changes_seen, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
